[design/nearest_landmark_locator_core_assert.svh]
// ----------------------------------------------------------------------------
// Nearest landmark locator - assertion macros
// Shared property wrappers for the port checker, clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NEAREST_LANDMARK_LOCATOR_CORE_ASSERT_SVH
`define NEAREST_LANDMARK_LOCATOR_CORE_ASSERT_SVH

// Same-cycle implication
`define NLL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define NLL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/nll_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest landmark locator - package
// Beat types, sizes, mode codes and the reset grid of the landmark table.
// ----------------------------------------------------------------------------
package nll_pkg;

    localparam int NUM_LM     = 16;
    localparam int LM_IDX_W   = 4;
    localparam int CNT_W      = 5;
    localparam int COORD_W    = 16;
    localparam int DIST_W     = 17;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int SUM_W      = SQ_W + 1;
    localparam int GRID_COUNT = 9;

    localparam logic [CNT_W-1:0] IN_USE_RST = 5'd9;
    localparam logic [CNT_W-1:0] IN_USE_MAX = 5'd16;
    localparam logic [CNT_W-1:0] IN_USE_MIN = 5'd1;

    // 1.1 m in Q8.8, rounded to nearest
    localparam logic signed [COORD_W-1:0] GRID_STEP = 16'sd282;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_LOCATE = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_point;

    typedef struct packed {
        logic [1:0]                mode;
        logic [LM_IDX_W-1:0]       landmark_index;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
    } t_cmd;

    typedef struct packed {
        logic [LM_IDX_W-1:0] closest_index;
        logic [DIST_W-1:0]   distance;
        logic                found;
    } t_rsp;

    // Reset content of table entry idx: 3x3 grid, rest at the origin
    function automatic t_point grid_point(input int idx);
        t_point p;
        p.x = '0;
        p.y = '0;
        case (idx)
            0: begin p.x = -GRID_STEP; p.y = -GRID_STEP; end
            1: begin p.x = -GRID_STEP; p.y = '0;         end
            2: begin p.x = -GRID_STEP; p.y = GRID_STEP;  end
            3: begin p.x = '0;         p.y = GRID_STEP;  end
            4: begin p.x = '0;         p.y = '0;         end
            5: begin p.x = '0;         p.y = -GRID_STEP; end
            6: begin p.x = GRID_STEP;  p.y = -GRID_STEP; end
            7: begin p.x = GRID_STEP;  p.y = '0;         end
            8: begin p.x = GRID_STEP;  p.y = GRID_STEP;  end
            default: begin p.x = '0;   p.y = '0;         end
        endcase
        return p;
    endfunction

endpackage

[design/nll_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest landmark locator - landmark cell
// Holds one landmark position; loads a new one, or takes its neighbor's
// value when the ring rotates.
// ----------------------------------------------------------------------------
module nll_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  nll_pkg::t_point i_rst_val,
    input  logic           i_load,
    input  nll_pkg::t_point i_load_val,
    input  logic           i_shift,
    input  nll_pkg::t_point i_next,
    output nll_pkg::t_point o_val
);

    nll_pkg::t_point r_val;
    nll_pkg::t_point n_val;

    // Pick load, rotate or hold
    always_comb begin
        n_val = r_val;
        if (i_load) begin
            n_val = i_load_val;
        end else if (i_shift) begin
            n_val = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= i_rst_val;
        end else begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;

endmodule

[design/nll_isqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest landmark locator - integer square root
// Floor square root, one result bit per cycle (two radicand bits consumed).
// ----------------------------------------------------------------------------
module nll_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [nll_pkg::SUM_W-1:0]  i_rad,
    output logic                       o_done,
    output logic [nll_pkg::DIST_W-1:0] o_root
);

    localparam int RAD_W = 2 * nll_pkg::DIST_W;
    localparam int REM_W = nll_pkg::DIST_W + 1;
    localparam int TRY_W = REM_W + 2;
    localparam int ITR_W = $clog2(nll_pkg::DIST_W);
    localparam logic [ITR_W-1:0] LAST_ITER = ITR_W'(nll_pkg::DIST_W - 1);

    logic                       r_run;
    logic                       r_done;
    logic [ITR_W-1:0]           r_iter;
    logic [RAD_W-1:0]           r_rad;
    logic [REM_W-1:0]           r_rem;
    logic [nll_pkg::DIST_W-1:0] r_root;

    logic [TRY_W-1:0] rem_sh;
    logic [TRY_W-1:0] trial;
    logic             take;

    // Bring down two bits and try root*4+1
    always_comb begin
        rem_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};
        take   = (rem_sh >= trial);
    end

    // Advance control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_iter <= '0;
            end else if (r_run) begin
                r_iter <= r_iter + 1'b1;
                if (r_iter == LAST_ITER) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Iterate datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= RAD_W'(i_rad);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_run) begin
            r_rad <= {r_rad[RAD_W-3:0], 2'b00};
            if (take) begin
                r_rem  <= REM_W'(rem_sh - trial);
                r_root <= {r_root[nll_pkg::DIST_W-2:0], 1'b1};
            end else begin
                r_rem  <= REM_W'(rem_sh);
                r_root <= {r_root[nll_pkg::DIST_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

[design/nearest_landmark_locator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest landmark locator - top level
// Landmark ring of cells, distance pipeline, nearest pick and square root.
// ----------------------------------------------------------------------------
// Results come out as a one-cycle strobe and cannot be held off: capture
// o_rsp whenever o_rsp_valid is high. A load (mode 0) gives no beat. A
// position update (mode 1) rotates the 16-cell landmark ring once past
// the distance pipeline, then runs the bit-serial square root, with busy
// high until the result cycle. A distance query (mode 2) on an entry in
// use skips the rotation; one on an entry not in use answers the next
// cycle. The ring rotation and the square root, one result bit per cycle,
// set the latency.
// Write landmarks_in_use only while busy and start are low; o_cfg_ready
// shows when a write is taken.
// ----------------------------------------------------------------------------
module nearest_landmark_locator_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  nll_pkg::t_cmd                i_cmd,
    output logic                         o_rsp_valid,
    output nll_pkg::t_rsp                o_rsp,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [nll_pkg::CNT_W-1:0]    i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_ROOT  = 4'b1000
    } t_state;

    localparam logic [nll_pkg::LM_IDX_W-1:0] LAST_IDX = nll_pkg::LM_IDX_W'(nll_pkg::NUM_LM - 1);

    t_state r_state;
    t_state n_state;

    logic [nll_pkg::CNT_W-1:0]    r_in_use;
    logic [nll_pkg::CNT_W-1:0]    used_cnt;
    nll_pkg::t_point              r_robot;
    logic [nll_pkg::LM_IDX_W-1:0] r_cnt;
    logic                         r_first;

    // Distance pipeline
    logic                         r_a_v;
    logic [nll_pkg::LM_IDX_W-1:0] r_a_idx;
    logic [nll_pkg::COORD_W-1:0]  r_ax;
    logic [nll_pkg::COORD_W-1:0]  r_ay;
    logic                         r_b_v;
    logic [nll_pkg::LM_IDX_W-1:0] r_b_idx;
    logic [nll_pkg::SQ_W-1:0]     r_sqx;
    logic [nll_pkg::SQ_W-1:0]     r_sqy;
    logic [nll_pkg::SUM_W-1:0]    r_best_d;
    logic [nll_pkg::LM_IDX_W-1:0] r_best_idx;

    logic                         r_rsp_valid;
    nll_pkg::t_rsp                r_rsp;

    nll_pkg::t_point              cell_val [nll_pkg::NUM_LM];
    nll_pkg::t_point              head;
    nll_pkg::t_point              load_val;
    logic                         accept;
    logic                         scan_shift;
    logic                         feed_v;
    logic [nll_pkg::LM_IDX_W-1:0] feed_idx;
    logic signed [nll_pkg::COORD_W:0] dx;
    logic signed [nll_pkg::COORD_W:0] dy;
    logic [nll_pkg::COORD_W:0]    adx;
    logic [nll_pkg::COORD_W:0]    ady;
    logic [nll_pkg::SUM_W-1:0]    sum;
    logic                         query_hit;
    logic                         root_start;
    logic                         root_done;
    logic [nll_pkg::DIST_W-1:0]   root;

    assign accept      = start && (r_state == S_IDLE);
    assign busy        = (r_state != S_IDLE);
    // Take configuration only while idle and no command is offered
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign scan_shift  = (r_state == S_SCAN);
    assign load_val    = '{x: i_cmd.pos_x, y: i_cmd.pos_y};

    // Clamp the in-use count to 1..16
    always_comb begin
        if (r_in_use < nll_pkg::IN_USE_MIN) begin
            used_cnt = nll_pkg::IN_USE_MIN;
        end else if (r_in_use > nll_pkg::IN_USE_MAX) begin
            used_cnt = nll_pkg::IN_USE_MAX;
        end else begin
            used_cnt = r_in_use;
        end
    end

    assign query_hit = ({1'b0, i_cmd.landmark_index} < used_cnt);

    // Landmark ring: cell i takes cell i+1, cell 0 faces the pipeline
    for (genvar g = 0; g < nll_pkg::NUM_LM; g++) begin : g_cell
        nll_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_rst_val  (nll_pkg::grid_point(g)),
            .i_load     (accept && (i_cmd.mode == nll_pkg::MODE_LOAD) &&
                         (i_cmd.landmark_index == nll_pkg::LM_IDX_W'(g))),
            .i_load_val (load_val),
            .i_shift    (scan_shift),
            .i_next     (cell_val[(g + 1) % nll_pkg::NUM_LM]),
            .o_val      (cell_val[g])
        );
    end

    // Select what enters the pipeline
    always_comb begin
        if (r_state == S_SCAN) begin
            head     = cell_val[0];
            feed_v   = ({1'b0, r_cnt} < used_cnt);
            feed_idx = r_cnt;
        end else begin
            head     = cell_val[i_cmd.landmark_index];
            feed_v   = accept && (i_cmd.mode == nll_pkg::MODE_QUERY) && query_hit;
            feed_idx = i_cmd.landmark_index;
        end
    end

    // Absolute differences
    always_comb begin
        dx  = (nll_pkg::COORD_W + 1)'(r_robot.x) - (nll_pkg::COORD_W + 1)'(head.x);
        dy  = (nll_pkg::COORD_W + 1)'(r_robot.y) - (nll_pkg::COORD_W + 1)'(head.y);
        adx = dx[nll_pkg::COORD_W] ? (nll_pkg::COORD_W + 1)'(-dx) : dx;
        ady = dy[nll_pkg::COORD_W] ? (nll_pkg::COORD_W + 1)'(-dy) : dy;
        sum = {1'b0, r_sqx} + {1'b0, r_sqy};
    end

    // Sequencer
    always_comb begin
        n_state    = r_state;
        root_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_cmd.mode == nll_pkg::MODE_LOCATE)) begin
                    n_state = S_SCAN;
                end else if (accept && (i_cmd.mode == nll_pkg::MODE_QUERY) && query_hit) begin
                    n_state = S_DRAIN;
                end
            end
            S_SCAN: begin
                if (r_cnt == LAST_IDX) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_a_v && !r_b_v) begin
                    n_state    = S_ROOT;
                    root_start = 1'b1;
                end
            end
            S_ROOT: begin
                if (root_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_use    <= nll_pkg::IN_USE_RST;
            r_robot     <= '0;
            r_cnt       <= '0;
            r_first     <= 1'b0;
            r_a_v       <= 1'b0;
            r_b_v       <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_a_v       <= feed_v;
            r_b_v       <= r_a_v;
            r_rsp_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_in_use <= i_cfg_data;
            end
            if (accept && (i_cmd.mode == nll_pkg::MODE_LOCATE)) begin
                r_robot <= load_val;
            end
            if (accept) begin
                r_first <= 1'b1;
                r_cnt   <= '0;
            end else if (r_b_v) begin
                r_first <= 1'b0;
            end
            if (r_state == S_SCAN) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (accept && (i_cmd.mode == nll_pkg::MODE_QUERY) && !query_hit) begin
                r_rsp_valid <= 1'b1;
            end else if ((r_state == S_ROOT) && root_done) begin
                r_rsp_valid <= 1'b1;
            end
        end
    end

    // Pipeline payload: square, then keep the nearest (lower index on ties)
    always_ff @(posedge i_clk) begin
        r_a_idx <= feed_idx;
        r_ax    <= adx[nll_pkg::COORD_W-1:0];
        r_ay    <= ady[nll_pkg::COORD_W-1:0];
        r_b_idx <= r_a_idx;
        r_sqx   <= r_ax * r_ax;
        r_sqy   <= r_ay * r_ay;
        if (r_b_v && (r_first || (sum < r_best_d))) begin
            r_best_d   <= sum;
            r_best_idx <= r_b_idx;
        end
    end

    // Result beat
    always_ff @(posedge i_clk) begin
        if (accept && (i_cmd.mode == nll_pkg::MODE_QUERY) && !query_hit) begin
            r_rsp <= '{closest_index: i_cmd.landmark_index, distance: '0, found: 1'b0};
        end else if ((r_state == S_ROOT) && root_done) begin
            r_rsp <= '{closest_index: r_best_idx, distance: root, found: 1'b1};
        end
    end

    nll_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_rad   (r_best_d),
        .o_done  (root_done),
        .o_root  (root)
    );

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

[design/nll_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest landmark locator - port checker
// Watches the top level's ports for command and result ordering rules.
// ----------------------------------------------------------------------------
`include "nearest_landmark_locator_core_assert.svh"

module nll_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input nll_pkg::t_cmd             i_cmd,
    input logic                      o_rsp_valid,
    input nll_pkg::t_rsp             o_rsp,
    input logic                      i_cfg_valid,
    input logic                      o_cfg_ready
);

    logic acc;
    logic acc_load;
    logic acc_locate;
    logic acc_query;
    logic rsp_miss;

    assign acc        = start && !busy;
    assign acc_load   = acc && (i_cmd.mode == nll_pkg::MODE_LOAD);
    assign acc_locate = acc && (i_cmd.mode == nll_pkg::MODE_LOCATE);
    assign acc_query  = acc && (i_cmd.mode == nll_pkg::MODE_QUERY);
    assign rsp_miss   = o_rsp_valid && !o_rsp.found;

    // A position update keeps the block busy
    `NLL_ASSERT_NXT(a_locate_busy, acc_locate, busy, "locate not busy")
    // A load gives no beat and frees the block at once
    `NLL_ASSERT_NXT(a_load_quiet, acc_load, !o_rsp_valid && !busy, "load gave a beat")
    // A miss reports zero distance
    `NLL_ASSERT_IMP(a_miss_zero, rsp_miss, o_rsp.distance == '0, "miss with distance")
    // A miss only follows a query accepted the cycle before
    `NLL_ASSERT_IMP(a_miss_src, rsp_miss, $past(acc_query), "stray miss")
    // Configuration is taken only while idle
    `NLL_ASSERT_IMP(a_cfg_idle, i_cfg_valid && o_cfg_ready, !busy, "config while busy")

endmodule

bind nearest_landmark_locator_core nll_checker u_nll_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_cmd       (i_cmd),
    .o_rsp_valid (o_rsp_valid),
    .o_rsp       (o_rsp),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);

[sim/tb_nearest_landmark_locator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest landmark locator - testbench
// Drives load, locate, query and unused-mode commands through the start/busy
// port and checks every strobed response, field by field and in order,
// against a local model of the landmark table. Covers the reset grid, the
// lower-index tie break, coordinate extremes and the clamped in-use count,
// then runs random commands under several sender idle rates.
// ----------------------------------------------------------------------------
module tb_nearest_landmark_locator_core;

    localparam int SETTLE_CYCLES = 60;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 150;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        start       = 1'b0;
    logic                        busy;
    nll_pkg::t_cmd               i_cmd       = '0;
    logic                        o_rsp_valid;
    nll_pkg::t_rsp               o_rsp;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [nll_pkg::CNT_W-1:0]   i_cfg_data  = '0;

    // Local copy of the block state
    logic signed [nll_pkg::COORD_W-1:0] lm_x [nll_pkg::NUM_LM];
    logic signed [nll_pkg::COORD_W-1:0] lm_y [nll_pkg::NUM_LM];
    logic signed [nll_pkg::COORD_W-1:0] robot_x;
    logic signed [nll_pkg::COORD_W-1:0] robot_y;
    logic [nll_pkg::CNT_W-1:0]          in_use_reg;

    nll_pkg::t_rsp expected_fixes [$];
    int   err_count        = 0;
    int   cycle_count      = 0;
    int   sender_idle_pct  = 0;

    nearest_landmark_locator_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Load the post-reset table: 3x3 grid at +/-1.1 m, rest at the origin
    task automatic table_reset();
        lm_x[0] = -16'sd282; lm_y[0] = -16'sd282;
        lm_x[1] = -16'sd282; lm_y[1] = 16'sd0;
        lm_x[2] = -16'sd282; lm_y[2] = 16'sd282;
        lm_x[3] = 16'sd0;    lm_y[3] = 16'sd282;
        lm_x[4] = 16'sd0;    lm_y[4] = 16'sd0;
        lm_x[5] = 16'sd0;    lm_y[5] = -16'sd282;
        lm_x[6] = 16'sd282;  lm_y[6] = -16'sd282;
        lm_x[7] = 16'sd282;  lm_y[7] = 16'sd0;
        lm_x[8] = 16'sd282;  lm_y[8] = 16'sd282;
        for (int i = 9; i < nll_pkg::NUM_LM; i++) begin
            lm_x[i] = '0;
            lm_y[i] = '0;
        end
        robot_x    = '0;
        robot_y    = '0;
        in_use_reg = 5'd9;
    endtask

    function automatic longint unsigned sq_dist(
        input logic signed [nll_pkg::COORD_W-1:0] ax,
        input logic signed [nll_pkg::COORD_W-1:0] ay,
        input logic signed [nll_pkg::COORD_W-1:0] bx,
        input logic signed [nll_pkg::COORD_W-1:0] by);
        longint dx;
        longint dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        return longint'(dx * dx + dy * dy);
    endfunction

    // Floor square root, one result bit per step from the top
    function automatic logic [nll_pkg::DIST_W-1:0] floor_root(input longint unsigned s);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = nll_pkg::DIST_W - 1; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= s)
                r = t;
        end
        return r[nll_pkg::DIST_W-1:0];
    endfunction

    // Apply one command to the local state; return 1 when it yields a response
    function automatic bit locate_step(input nll_pkg::t_cmd c, output nll_pkg::t_rsp r);
        int              n;
        int              best;
        longint unsigned d;
        longint unsigned best_d;
        n = in_use_reg;
        if (n < 1)
            n = 1;
        if (n > nll_pkg::NUM_LM)
            n = nll_pkg::NUM_LM;
        r = '0;
        case (c.mode)
            nll_pkg::MODE_LOAD: begin
                lm_x[c.landmark_index] = c.pos_x;
                lm_y[c.landmark_index] = c.pos_y;
                return 1'b0;
            end
            nll_pkg::MODE_LOCATE: begin
                robot_x = c.pos_x;
                robot_y = c.pos_y;
                best    = 0;
                best_d  = 0;
                for (int i = 0; i < n; i++) begin
                    d = sq_dist(robot_x, robot_y, lm_x[i], lm_y[i]);
                    if (i == 0 || d < best_d) begin
                        best   = i;
                        best_d = d;
                    end
                end
                r.closest_index = best[nll_pkg::LM_IDX_W-1:0];
                r.distance      = floor_root(best_d);
                r.found         = 1'b1;
                return 1'b1;
            end
            nll_pkg::MODE_QUERY: begin
                r.closest_index = c.landmark_index;
                if (int'(c.landmark_index) < n) begin
                    d = sq_dist(robot_x, robot_y, lm_x[c.landmark_index],
                                lm_y[c.landmark_index]);
                    r.distance = floor_root(d);
                    r.found    = 1'b1;
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic nll_pkg::t_cmd cmd_of(input logic [1:0] mode, input int idx,
                                             input int x, input int y);
        nll_pkg::t_cmd c;
        c.mode           = mode;
        c.landmark_index = idx[nll_pkg::LM_IDX_W-1:0];
        c.pos_x          = x[nll_pkg::COORD_W-1:0];
        c.pos_y          = y[nll_pkg::COORD_W-1:0];
        return c;
    endfunction

    // Half near the grid, some full range, some at the rails
    function automatic logic signed [nll_pkg::COORD_W-1:0] random_coord();
        int pick;
        logic signed [nll_pkg::COORD_W-1:0] v;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            v = nll_pkg::COORD_W'($urandom_range(0, 2047)) - 16'sd1024;
        else if (pick < 8)
            v = nll_pkg::COORD_W'($urandom);
        else if (pick == 8)
            v = 16'sh8000;
        else
            v = 16'sh7fff;
        return v;
    endfunction

    function automatic nll_pkg::t_cmd random_cmd();
        nll_pkg::t_cmd c;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            c.mode = nll_pkg::MODE_LOAD;
        else if (pick < 65)
            c.mode = nll_pkg::MODE_LOCATE;
        else if (pick < 95)
            c.mode = nll_pkg::MODE_QUERY;
        else
            c.mode = nll_pkg::MODE_NONE;
        c.landmark_index = nll_pkg::LM_IDX_W'($urandom_range(0, nll_pkg::NUM_LM - 1));
        c.pos_x          = random_coord();
        c.pos_y          = random_coord();
        return c;
    endfunction

    // Send one command beat; start stays high on return unless the caller drops it
    task automatic send_cmd(input nll_pkg::t_cmd c);
        nll_pkg::t_rsp r;
        if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(0, 99) < sender_idle_pct);
        end
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        if (locate_step(c, r))
            expected_fixes = {expected_fixes, r};
    endtask

    // Drop start, drain responses and let any result-less command finish
    task automatic wait_quiet();
        start <= 1'b0;
        while (expected_fixes.size() != 0 || busy)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_in_use(input logic [nll_pkg::CNT_W-1:0] v);
        wait_quiet();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        in_use_reg = v;
        i_cfg_valid <= 1'b0;
    endtask

    // Check each response beat against the oldest expectation
    always @(posedge i_clk) begin
        nll_pkg::t_rsp want;
        if (i_rst_n && o_rsp_valid) begin
            if (expected_fixes.size() == 0) begin
                $error("unexpected response: closest_index %0d distance %0d found %0d",
                       o_rsp.closest_index, o_rsp.distance, o_rsp.found);
                err_count++;
            end else begin
                want = expected_fixes.pop_front();
                if (o_rsp.closest_index !== want.closest_index) begin
                    $error("closest_index: expected %0d, actual %0d",
                           want.closest_index, o_rsp.closest_index);
                    err_count++;
                end
                if (o_rsp.distance !== want.distance) begin
                    $error("distance: expected %0d, actual %0d",
                           want.distance, o_rsp.distance);
                    err_count++;
                end
                if (o_rsp.found !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, o_rsp.found);
                    err_count++;
                end
            end
        end
    end

    // Query the reset grid from the origin, including entries not in use
    task automatic test_reset_grid();
        for (int i = 0; i < nll_pkg::GRID_COUNT; i++)
            send_cmd(cmd_of(nll_pkg::MODE_QUERY, i, 0, 0));
        send_cmd(cmd_of(nll_pkg::MODE_QUERY, 9, 0, 0));
        send_cmd(cmd_of(nll_pkg::MODE_QUERY, 15, 0, 0));
        send_cmd(cmd_of(nll_pkg::MODE_LOCATE, 0, 0, 0));
    endtask

    // Point equidistant from four grid entries: the lowest index must win
    task automatic test_tie_break();
        send_cmd(cmd_of(nll_pkg::MODE_LOCATE, 0, 141, 141));
        send_cmd(cmd_of(nll_pkg::MODE_QUERY, 8, 0, 0));
    endtask

    // Rail coordinates, the longest distance and the unused mode
    task automatic test_extremes();
        set_in_use(5'd16);
        send_cmd(cmd_of(nll_pkg::MODE_LOAD, 15, 32767, 32767));
        send_cmd(cmd_of(nll_pkg::MODE_LOAD, 0, -32768, -32768));
        send_cmd(cmd_of(nll_pkg::MODE_LOCATE, 3, -32768, -32768));
        send_cmd(cmd_of(nll_pkg::MODE_QUERY, 15, 0, 0));
        send_cmd(cmd_of(nll_pkg::MODE_NONE, 15, 12345, -4321));
        send_cmd(cmd_of(nll_pkg::MODE_LOCATE, 0, 32767, 32767));
        send_cmd(cmd_of(nll_pkg::MODE_QUERY, 0, 0, 0));
    endtask

    // Count below one and above the table size are clamped
    task automatic test_in_use_limits();
        set_in_use(5'd0);
        send_cmd(cmd_of(nll_pkg::MODE_LOCATE, 0, 100, -100));
        send_cmd(cmd_of(nll_pkg::MODE_QUERY, 1, 0, 0));
        set_in_use(5'd31);
        send_cmd(cmd_of(nll_pkg::MODE_QUERY, 15, 0, 0));
        send_cmd(cmd_of(nll_pkg::MODE_LOCATE, 0, 0, 0));
        set_in_use(5'd1);
        send_cmd(cmd_of(nll_pkg::MODE_QUERY, 0, 0, 0));
        send_cmd(cmd_of(nll_pkg::MODE_QUERY, 1, 0, 0));
    endtask

    task automatic test_random(input int idle_pct, input logic [nll_pkg::CNT_W-1:0] in_use);
        set_in_use(in_use);
        sender_idle_pct = idle_pct;
        for (int k = 0; k < PHASE_ITEMS; k++)
            send_cmd(random_cmd());
    endtask

    initial begin
        table_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idle_pct = 22;
        test_reset_grid();
        test_tie_break();
        test_extremes();
        test_in_use_limits();
        test_random(22, 5'd16);
        test_random(79, nll_pkg::CNT_W'($urandom_range(1, 15)));
        test_random(0, nll_pkg::CNT_W'($urandom_range(0, 31)));

        wait_quiet();
        if (err_count == 0 && expected_fixes.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
